FILE: hw/rtl/mbrs_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte step for the Modbus RTU register slave.
package mbrs_pkg;

   localparam int FRAME_DEPTH_DEF   = 256;
   localparam int NUM_MEAS_REGS_DEF = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   localparam logic [7:0]  REPLY_ID        = 8'h80;
   localparam logic [7:0]  FN_READ_INPUT   = 8'h04;
   localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
   localparam logic [7:0]  ECHO_LAST       = 8'd7;
   localparam logic [7:0]  WRITE_REPLY_LEN = 8'd8;
   localparam logic [7:0]  READ_HDR_LEN    = 8'd3;
   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;

   typedef enum logic [1:0] {
      ACT_BYTE = 2'd0,
      ACT_END  = 2'd1,
      ACT_LOAD = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  rx_byte;
      logic        meas_index;
      logic [15:0] meas_value;
   } cmd_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/modbus_rtu_register_slave_top.sv
// Top level of the Modbus RTU register slave: configuration port, front end and back end.
// A Modbus RTU slave that answers function 0x04 (read measurement registers) and
// function 0x06 (write the PWM register). Each input transfer carries one action:
// a received byte, a frame end or a measurement load. A two-entry command queue
// sits between the input port and the executing back end, so input transfers are
// taken while a reply is still being sent. A frame end walks the frame buffer one
// byte at a time, each with a registered memory read and then the CRC step, over
// max(count, 8) bytes, then a check state; reply bytes then leave at up to one per
// cycle while the receiver takes them, through the output register, 2n+5 bytes
// for a read of n words and 8 for a PWM write. Frames that fail the address,
// length or CRC check, name an unknown function or ask for a range past the
// register count get no reply. The station address is the register at byte
// address 0 of the configuration port and resets to 1.
module modbus_rtu_register_slave_top #(
   parameter int FRAME_DEPTH   = mbrs_pkg::FRAME_DEPTH_DEF,
   parameter int NUM_MEAS_REGS = mbrs_pkg::NUM_MEAS_REGS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_meas_index,
   input  logic [15:0] req_meas_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last_byte,
   output logic [15:0] rsp_pwm_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic              slave_address_ff;
   logic [7:0]        slave_addr_ff;
   logic              q_valid;
   logic              q_ready;
   mbrs_pkg::cmd_type q_cmd;

   // Register transfer completes in the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {24'h0, slave_addr_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff    <= 8'd1;
         slave_address_ff <= 1'b0;
      end else begin
         // mark that a write landed, used only to qualify checks below
         slave_address_ff <= 1'b0;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
            slave_addr_ff    <= csr_pwdata[7:0];
            slave_address_ff <= 1'b1;
         end
      end
   end

   mbrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_rx_byte    (req_rx_byte),
      .req_meas_index (req_meas_index),
      .req_meas_value (req_meas_value),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_cmd          (q_cmd)
   );

   mbrs_back #(
      .FRAME_DEPTH   (FRAME_DEPTH),
      .NUM_MEAS_REGS (NUM_MEAS_REGS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .slave_address (slave_addr_ff),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .q_cmd         (q_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last_byte (rsp_last_byte),
      .rsp_pwm_value (rsp_pwm_value)
   );

   // After the final byte of a reply is taken, nothing follows in the next cycle.
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_byte |=> !rsp_valid)
      else $error("reply byte followed the final byte without a gap");

   // A station address write is read back at once.
   a_addr_rb: assert property (@(posedge clock) disable iff (reset)
      slave_address_ff |-> (csr_paddr[2] || csr_prdata[7:0] == $past(csr_pwdata[7:0])))
      else $error("station address read-back mismatch");

   // The command queue drains only while the back end is idle, so no reply starts straight after a byte command.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> !(rsp_valid && $rose(rsp_valid) && $past(q_cmd.action) ==
      mbrs_pkg::ACT_BYTE))
      else $error("reply started straight after a byte command");

endmodule

FILE: hw/rtl/mbrs_front.sv
// Front end: accepts input transfers, drops idle actions and queues commands for the back end.
module mbrs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_meas_index,
   input  logic [15:0]      req_meas_value,
   output logic             q_valid,
   input  logic             q_ready,
   output mbrs_pkg::cmd_type q_cmd
);

   mbrs_pkg::cmd_type                      qmem_ff [mbrs_pkg::QUEUE_DEPTH];
   logic [mbrs_pkg::QUEUE_AW-1:0]          wr_ptr_ff;
   logic [mbrs_pkg::QUEUE_AW-1:0]          rd_ptr_ff;
   logic [mbrs_pkg::QUEUE_AW:0]            cnt_ff;
   mbrs_pkg::cmd_type                      cmd;
   logic                                   push;
   logic                                   pop;

   always_comb begin
      cmd.action     = mbrs_pkg::action_type'(req_action);
      cmd.rx_byte    = req_rx_byte;
      cmd.meas_index = req_meas_index;
      cmd.meas_value = req_meas_value;
   end

   assign req_ready = (cnt_ff != (mbrs_pkg::QUEUE_AW+1)'(mbrs_pkg::QUEUE_DEPTH));
   // idle actions are taken and dropped here
   assign push      = req_valid && req_ready && (cmd.action != mbrs_pkg::ACT_NONE);
   assign q_valid   = (cnt_ff != '0);
   assign q_cmd     = qmem_ff[rd_ptr_ff];
   assign pop       = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         qmem_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

FILE: hw/rtl/mbrs_back.sv
// Back end: frame buffer, frame check sequencer, register file and reply output stage.
module mbrs_back #(
   parameter int FRAME_DEPTH   = mbrs_pkg::FRAME_DEPTH_DEF,
   parameter int NUM_MEAS_REGS = mbrs_pkg::NUM_MEAS_REGS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        slave_address,
   input  logic              q_valid,
   output logic              q_ready,
   input  mbrs_pkg::cmd_type q_cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last_byte,
   output logic [15:0]       rsp_pwm_value
);

   localparam int CW  = $clog2(FRAME_DEPTH);
   localparam int MIW = (NUM_MEAS_REGS > 1) ? $clog2(NUM_MEAS_REGS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_TAKE,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type        state_ff;
   logic [7:0]       mem [FRAME_DEPTH];
   logic [7:0]       rdata_ff;
   logic [CW-1:0]    cnt_ff;
   logic [CW-1:0]    fcnt_ff;
   logic [CW-1:0]    idx_ff;
   logic [15:0]      crc_ff;
   logic [15:0]      got_ff;
   logic             addr_ok_ff;
   logic [7:0]       b_ff [1:7];
   logic [15:0]      meas_ff [NUM_MEAS_REGS];
   logic [15:0]      pwm_ff;
   logic             is_read_ff;
   logic [7:0]       k_ff;
   logic [7:0]       total_ff;
   logic [15:0]      rc_ff;
   logic             rsp_valid_ff;
   logic [7:0]       tx_byte_ff;
   logic             last_ff;
   logic [15:0]      pwm_out_ff;

   logic             wr_en;
   logic [CW:0]      idx_x;
   logic [CW:0]      fcnt_x;
   logic [CW-1:0]    last_walk;
   logic [16:0]      range_sum;
   logic [7:0]       n2;
   logic [7:0]       koff;
   logic [7:0]       widx;
   logic [15:0]      word;
   logic [7:0]       byte_out;
   logic             out_free;

   assign q_ready = (state_ff == S_IDLE);
   assign wr_en   = q_valid && q_ready && (q_cmd.action == mbrs_pkg::ACT_BYTE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_ff] <= q_cmd.rx_byte;
      end
      rdata_ff <= mem[idx_ff];
   end

   assign idx_x     = {1'b0, idx_ff};
   assign fcnt_x    = {1'b0, fcnt_ff};
   assign last_walk = (fcnt_ff > CW'(7)) ? (fcnt_ff - 1'b1) : CW'(7);
   assign range_sum = {1'b0, b_ff[2], b_ff[3]} + {1'b0, b_ff[4], b_ff[5]};
   assign n2        = {b_ff[5][6:0], 1'b0};
   assign koff      = k_ff - mbrs_pkg::READ_HDR_LEN;
   assign widx      = b_ff[3] + {1'b0, koff[7:1]};
   assign word      = meas_ff[widx[MIW-1:0]];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (is_read_ff) begin
         if (k_ff == 8'd0) begin
            byte_out = mbrs_pkg::REPLY_ID;
         end else if (k_ff == 8'd1) begin
            byte_out = mbrs_pkg::FN_READ_INPUT;
         end else if (k_ff == 8'd2) begin
            byte_out = n2;
         end else if (k_ff < n2 + mbrs_pkg::READ_HDR_LEN) begin
            byte_out = koff[0] ? word[7:0] : word[15:8];
         end else if (k_ff == n2 + mbrs_pkg::READ_HDR_LEN) begin
            byte_out = rc_ff[7:0];
         end else begin
            byte_out = rc_ff[15:8];
         end
      end else begin
         byte_out = (k_ff == 8'd0) ? mbrs_pkg::REPLY_ID : b_ff[k_ff[2:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fcnt_ff      <= '0;
         idx_ff       <= '0;
         pwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_MEAS_REGS; i++) begin
            meas_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  case (q_cmd.action)
                     mbrs_pkg::ACT_BYTE: begin
                        cnt_ff <= (cnt_ff == CW'(FRAME_DEPTH - 1)) ? '0 : cnt_ff + 1'b1;
                     end
                     mbrs_pkg::ACT_LOAD: begin
                        if (32'(q_cmd.meas_index) < NUM_MEAS_REGS) begin
                           meas_ff[q_cmd.meas_index] <= q_cmd.meas_value;
                        end
                     end
                     mbrs_pkg::ACT_END: begin
                        fcnt_ff <= cnt_ff;
                        cnt_ff  <= '0;
                        idx_ff  <= '0;
                        crc_ff  <= mbrs_pkg::CRC_INIT;
                        if (cnt_ff >= CW'(4)) begin
                           state_ff <= S_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_RD: begin
               state_ff <= S_TAKE;
            end
            S_TAKE: begin
               if (idx_ff == '0) begin
                  addr_ok_ff <= (rdata_ff == slave_address);
               end
               if (idx_x + 2'd2 < fcnt_x) begin
                  crc_ff <= mbrs_pkg::crc_add(crc_ff, rdata_ff);
               end
               if (idx_x + 2'd2 == fcnt_x) begin
                  got_ff[7:0] <= rdata_ff;
               end
               if (idx_x + 1'b1 == fcnt_x) begin
                  got_ff[15:8] <= rdata_ff;
               end
               if (idx_ff != '0 && idx_ff <= CW'(7)) begin
                  b_ff[idx_ff[2:0]] <= rdata_ff;
               end
               if (idx_ff == last_walk) begin
                  state_ff <= S_CHECK;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_CHECK: begin
               k_ff  <= '0;
               rc_ff <= mbrs_pkg::CRC_INIT;
               state_ff <= S_IDLE;
               if (addr_ok_ff && crc_ff == got_ff) begin
                  if (b_ff[1] == mbrs_pkg::FN_READ_INPUT) begin
                     if (range_sum <= 17'(NUM_MEAS_REGS)) begin
                        is_read_ff <= 1'b1;
                        total_ff   <= n2 + 8'd5;
                        state_ff   <= S_EMIT;
                     end
                  end else if (b_ff[1] == mbrs_pkg::FN_WRITE_SINGLE) begin
                     pwm_ff     <= {b_ff[4], b_ff[5]};
                     is_read_ff <= 1'b0;
                     total_ff   <= mbrs_pkg::WRITE_REPLY_LEN;
                     state_ff   <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  tx_byte_ff   <= byte_out;
                  last_ff      <= (k_ff + 1'b1 == total_ff);
                  pwm_out_ff   <= pwm_ff;
                  if (k_ff < n2 + mbrs_pkg::READ_HDR_LEN) begin
                     rc_ff <= mbrs_pkg::crc_add(rc_ff, byte_out);
                  end
                  k_ff <= k_ff + 1'b1;
                  if (k_ff + 1'b1 == total_ff) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = tx_byte_ff;
   assign rsp_last_byte = last_ff;
   assign rsp_pwm_value = pwm_out_ff;

endmodule
